@@ design/bicubic_image_scaler_macros.svh @@
// Assertion macros used by the scaler's top module.
`ifndef BICUBIC_IMAGE_SCALER_MACROS_SVH
`define BICUBIC_IMAGE_SCALER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define BIS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bicubic scaler check failed");

// The consequent holds in the cycle after the antecedent.
`define BIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bicubic scaler check failed");

`endif

@@ design/bis_pkg.sv @@
package bis_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;
  localparam int COORD_W    = $clog2(MAX_WIDTH);
  localparam int ADDR_W     = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 9;
  localparam int POS_W      = 36;
  localparam int BASE_W     = POS_W - 16;
  localparam int WEIGHT_W   = 27;
  localparam int LINE_W     = 38;
  localparam int SUM_W      = 66;
  localparam int OUT_SHIFT  = 2 + 6 * FRAC_BITS;

  typedef logic [COORD_W-1:0]          coord_t;
  typedef logic signed [WEIGHT_W-1:0]  weight_t;
  typedef logic signed [LINE_W-1:0]    line_t;
  typedef logic signed [SUM_W-1:0]     sum_t;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_INV_SCALE  = 2'd2,
    REG_COLOR_MODE = 2'd3
  } reg_idx_t;

  // Control from the sequencer to the accumulator.
  typedef struct packed {
    logic       line_clear;
    logic       mac;
    logic       vstep;
    logic [2:0] step;
    logic       sum_clear;
  } acc_ctrl_t;

  // Catmull-Rom tap weight, scaled by 2*F^3.
  function automatic weight_t calc_weight(logic [FRAC_BITS-1:0] x,
                                          logic [2*FRAC_BITS-1:0] x2,
                                          logic [3*FRAC_BITS-1:0] x3,
                                          logic [1:0] idx);
    logic signed [27:0] sx;
    logic signed [27:0] sx2;
    logic signed [27:0] sx3;
    logic signed [27:0] w;
    sx  = 28'(x);
    sx2 = 28'(x2);
    sx3 = 28'(x3);
    unique case (idx)
      2'd0:    w = -sx3 + (sx2 <<< (FRAC_BITS + 1)) - (sx <<< (2 * FRAC_BITS));
      2'd1:    w = 3 * sx3 - 5 * (sx2 <<< FRAC_BITS) + (28'sd1 <<< (3 * FRAC_BITS + 1));
      2'd2:    w = -3 * sx3 + 4 * (sx2 <<< FRAC_BITS) + (sx <<< (2 * FRAC_BITS));
      default: w = sx3 - (sx2 <<< FRAC_BITS);
    endcase
    return w[WEIGHT_W-1:0];
  endfunction

  // Neighbour n sits at base+n-1, saturated to 0..size-1.
  function automatic coord_t clamp_coord(logic [BASE_W-1:0] base, logic [1:0] n,
                                         logic [SIZE_W-1:0] size);
    logic [BASE_W:0] p;
    logic [BASE_W:0] lim;
    p   = {1'b0, base} + (BASE_W+1)'(n);
    lim = (BASE_W+1)'(size);
    if (p == '0) begin
      return '0;
    end else if (p > lim) begin
      return COORD_W'(size - 1'b1);
    end
    return COORD_W'(p - 1'b1);
  endfunction

  function automatic logic [7:0] to_pixel(sum_t s);
    if (s[SUM_W-1]) begin
      return 8'd0;
    end else if (s[SUM_W-2:OUT_SHIFT+8] != '0) begin
      return 8'd255;
    end
    return s[OUT_SHIFT+7:OUT_SHIFT];
  endfunction

endpackage

@@ design/bis_setup.sv @@
module bis_setup (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [11:0]                 query_col,
  input  logic [11:0]                 query_row,
  input  logic [23:0]                 inv_scale,
  input  logic [bis_pkg::SIZE_W-1:0]  width_eff,
  input  logic [bis_pkg::SIZE_W-1:0]  height_eff,
  output logic                        ready,
  output bis_pkg::weight_t            wx [4],
  output bis_pkg::weight_t            wy [4],
  output bis_pkg::coord_t             cols [4],
  output bis_pkg::coord_t             rows [4]
);
  import bis_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MX, S_MY, S_SQ, S_CU, S_WT} state_t;

  state_t                   state;
  logic [11:0]              qc;
  logic [11:0]              qr;
  logic [POS_W-1:0]         px;
  logic [POS_W-1:0]         py;
  logic [2*FRAC_BITS-1:0]   x2x;
  logic [2*FRAC_BITS-1:0]   x2y;
  logic [3*FRAC_BITS-1:0]   x3x;
  logic [3*FRAC_BITS-1:0]   x3y;
  logic [FRAC_BITS-1:0]     fx;
  logic [FRAC_BITS-1:0]     fy;
  logic [11:0]              mul_a;
  logic [POS_W-1:0]         mul_p;

  assign fx = px[15 -: FRAC_BITS];
  assign fy = py[15 -: FRAC_BITS];

  // One position multiplier serves both axes in turn.
  assign mul_a = (state == S_MX) ? qc : qr;
  assign mul_p = POS_W'(mul_a) * POS_W'(inv_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= 1'b0;
    end else begin
      ready <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            qc    <= query_col;
            qr    <= query_row;
            state <= S_MX;
          end
        end
        S_MX: begin
          px    <= mul_p;
          state <= S_MY;
        end
        S_MY: begin
          py    <= mul_p;
          state <= S_SQ;
        end
        S_SQ: begin
          x2x   <= fx * fx;
          x2y   <= fy * fy;
          state <= S_CU;
        end
        S_CU: begin
          x3x   <= (3*FRAC_BITS)'(x2x) * (3*FRAC_BITS)'(fx);
          x3y   <= (3*FRAC_BITS)'(x2y) * (3*FRAC_BITS)'(fy);
          state <= S_WT;
        end
        S_WT: begin
          for (int i = 0; i < 4; i++) begin
            wx[i]   <= calc_weight(fx, x2x, x3x, 2'(i));
            wy[i]   <= calc_weight(fy, x2y, x3y, 2'(i));
            cols[i] <= clamp_coord(px[POS_W-1:16], 2'(i), width_eff);
            rows[i] <= clamp_coord(py[POS_W-1:16], 2'(i), height_eff);
          end
          ready <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/bis_acc.sv @@
module bis_acc (
  input  logic                clk,
  input  bis_pkg::acc_ctrl_t  ctrl,
  input  bis_pkg::weight_t    wx_sel,
  input  bis_pkg::weight_t    wy_sel,
  input  logic [23:0]         pix,
  output bis_pkg::sum_t       sums [3]
);
  import bis_pkg::*;

  line_t               line [3];
  logic [1:0]          chan;
  line_t               line_sel;
  logic signed [19:0]  part;
  logic signed [46:0]  prod;
  sum_t                term;

  assign chan     = ctrl.step[2:1];
  assign line_sel = (chan == 2'd0) ? line[0] : ((chan == 2'd1) ? line[1] : line[2]);

  // The row weight times a 38-bit line sum is split into two halves on one multiplier.
  assign part = ctrl.step[0] ? 20'($signed(line_sel[LINE_W-1:19]))
                             : $signed({1'b0, line_sel[18:0]});
  assign prod = wy_sel * part;
  assign term = ctrl.step[0] ? (SUM_W'(prod) <<< 19) : SUM_W'(prod);

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (ctrl.line_clear) begin
        line[c] <= '0;
      end else if (ctrl.mac) begin
        line[c] <= line[c] + LINE_W'(wx_sel * $signed({1'b0, pix[8*c +: 8]}));
      end
      if (ctrl.sum_clear) begin
        sums[c] <= '0;
      end else if (ctrl.vstep && chan == 2'(c)) begin
        sums[c] <= sums[c] + term;
      end
    end
  end

endmodule

@@ design/bicubic_image_scaler.sv @@
// Bicubic (Catmull-Rom) scaler with a 256x256 frame store of 24-bit pixels.
// Items enter on start while busy is low. A load item (op 0) writes one pixel
// at (load_row, load_col) at the accepting edge and leaves busy low, so loads
// may follow in every cycle. A query item (op 1) raises busy; its position is
// the output coordinate times inverse_scale, and the 4x4 neighbourhood is read
// from the single-port frame memory one pixel a cycle. Each row of four is
// four reads, one drain and six steps of the shared row-weight multiplier,
// and a query runs from the accepting edge through setup and four such rows
// to the cycle in which done is high with chan_out0..2; busy falls in that cycle.
// The result stands on the ports for that single cycle and the receiver
// cannot hold it off. Registers must be written over the APB port only
// while idle; the block itself does not enforce it. Reset sets the
// registers to width 256, height 256, unit scale and grey mode and clears the
// sequencer; the frame store is not cleared and must be loaded before it is read.
`include "bicubic_image_scaler_macros.svh"

module bicubic_image_scaler (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         start,
  output logic         busy,
  input  logic         op,
  input  logic [7:0]   load_col,
  input  logic [7:0]   load_row,
  input  logic [7:0]   chan_in0,
  input  logic [7:0]   chan_in1,
  input  logic [7:0]   chan_in2,
  input  logic [11:0]  query_col,
  input  logic [11:0]  query_row,
  output logic         done,
  output logic [7:0]   chan_out0,
  output logic [7:0]   chan_out1,
  output logic [7:0]   chan_out2
);
  import bis_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SETUP, S_RD, S_LAST, S_VM, S_FIN} state_t;

  state_t             state;
  logic [8:0]         source_width;
  logic [8:0]         source_height;
  logic [23:0]        inverse_scale;
  logic               color_mode;
  logic [SIZE_W-1:0]  width_eff;
  logic [SIZE_W-1:0]  height_eff;
  logic               accept;
  logic               setup_ready;
  weight_t            wx [4];
  weight_t            wy [4];
  coord_t             cols [4];
  coord_t             rows [4];
  logic [1:0]         n;
  logic [1:0]         m;
  logic [2:0]         step;
  logic               rd_v;
  logic [1:0]         rd_n;
  logic [23:0]        mem [MAX_WIDTH*MAX_HEIGHT];
  logic [23:0]        q;
  logic [ADDR_W-1:0]  rd_addr;
  acc_ctrl_t          ctrl;
  sum_t               sums [3];

  assign pready = 1'b1;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign width_eff  = (source_width == '0) ? SIZE_W'(1) :
                      ((source_width > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : source_width);
  assign height_eff = (source_height == '0) ? SIZE_W'(1) :
                      ((source_height > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) :
                       source_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= 9'd256;
      source_height <= 9'd256;
      inverse_scale <= 24'd65536;
      color_mode    <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_SRC_WIDTH:  source_width  <= pwdata[8:0];
        REG_SRC_HEIGHT: source_height <= pwdata[8:0];
        REG_INV_SCALE:  inverse_scale <= pwdata[23:0];
        REG_COLOR_MODE: color_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_SRC_WIDTH:  prdata = 32'(source_width);
      REG_SRC_HEIGHT: prdata = 32'(source_height);
      REG_INV_SCALE:  prdata = 32'(inverse_scale);
      REG_COLOR_MODE: prdata = 32'(color_mode);
      default:        prdata = '0;
    endcase
  end

  bis_setup u_setup (
    .clk        (clk),
    .rst        (rst),
    .go         (accept && op),
    .query_col  (query_col),
    .query_row  (query_row),
    .inv_scale  (inverse_scale),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .ready      (setup_ready),
    .wx         (wx),
    .wy         (wy),
    .cols       (cols),
    .rows       (rows)
  );

  // Frame store: a load writes at its accepting edge, queries read one pixel a cycle.
  assign rd_addr = {rows[m], cols[n]};

  always_ff @(posedge clk) begin
    if (accept && !op) begin
      mem[{load_row, load_col}] <= color_mode ? {chan_in2, chan_in1, chan_in0}
                                              : {16'd0, chan_in0};
    end else if (state == S_RD) begin
      q <= mem[rd_addr];
    end
  end

  always_comb begin
    ctrl.line_clear = (state == S_RD) && (n == 2'd0);
    ctrl.mac        = rd_v;
    ctrl.vstep      = (state == S_VM);
    ctrl.step       = step;
    ctrl.sum_clear  = accept;
  end

  bis_acc u_acc (
    .clk    (clk),
    .ctrl   (ctrl),
    .wx_sel (wx[rd_n]),
    .wy_sel (wy[m]),
    .pix    (q),
    .sums   (sums)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      rd_v  <= 1'b0;
      n     <= '0;
      m     <= '0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      rd_v <= (state == S_RD);
      rd_n <= n;
      unique case (state)
        S_IDLE: begin
          if (accept && op) begin
            m     <= '0;
            n     <= '0;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (setup_ready) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          n <= n + 2'd1;
          if (n == 2'd3) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          step  <= '0;
          state <= S_VM;
        end
        S_VM: begin
          step <= step + 3'd1;
          if (step == 3'd5) begin
            if (m == 2'd3) begin
              state <= S_FIN;
            end else begin
              m     <= m + 2'd1;
              state <= S_RD;
            end
          end
        end
        S_FIN: begin
          done      <= 1'b1;
          chan_out0 <= to_pixel(sums[0]);
          chan_out1 <= color_mode ? to_pixel(sums[1]) : 8'd0;
          chan_out2 <= color_mode ? to_pixel(sums[2]) : 8'd0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BIS_ASSERT_SAME(a_done_idle, done, !busy)
  `BIS_ASSERT_NEXT(a_query_busy, accept && op, busy)
  `BIS_ASSERT_NEXT(a_load_free, accept && !op, !busy && !done)
  `BIS_ASSERT_NEXT(a_done_single, done, !done)

endmodule
